// ===== rtl/crcbs_pkg.sv =====
// Shared constants, types and the CRC-16 byte update of the checked block store.
package crcbs_pkg;

   localparam int MEM_BYTES       = 65536;
   localparam int MEM_AW          = $clog2(MEM_BYTES);
   localparam int MAX_DEVICES     = 4;
   localparam int DEV_W           = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
   localparam int NUM_DEV_REGS    = 4;
   localparam int MAX_BLOCK_BYTES = 4096;

   localparam int BLK_W      = 13;
   localparam int BLKNUM_W   = 15;
   localparam int DEVBYTES_W = 17;
   localparam int PAGE_W     = 16;
   localparam int BASE_W     = 18;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEV0_BYTES   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEV1_BYTES   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEV2_BYTES   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEV3_BYTES   = 3'd5;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD      = 2'd1;
   localparam logic [1:0] STATUS_MISMATCH = 2'd2;

   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'h8408;
   localparam logic [7:0]  ERASED_BYTE = 8'hFF;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_READ   = 2'd1,
      OP_ERASE  = 2'd2,
      OP_IGNORE = 2'd3
   } op_type;

   typedef struct packed {
      logic [BLK_W-1:0]                        blk_bytes;
      logic                                    blk_small;
      logic [MAX_DEVICES-1:0][BASE_W-1:0]      base;
      logic [MAX_DEVICES-1:0][PAGE_W-1:0]      used;
      logic [MAX_DEVICES-1:0][PAGE_W-1:0]      pd;
      logic [MAX_DEVICES-1:0][MEM_AW-1:0]      start;
   } geom_type;

   typedef struct packed {
      op_type              op;
      logic [BLKNUM_W-1:0] blk;
      logic [7:0]          din;
      logic                hit;
      logic [MEM_AW-1:0]   dbase;
      logic [MEM_AW-1:0]   cs;
   } entry_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] value);
      logic [15:0] c;
      c = crc ^ {8'h00, value};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== rtl/crcbs_ram.sv =====
// Generic single-port RAM with registered read.
module crcbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/crcbs_geom.sv =====
// Configuration registers and the serial divider that derives region geometry.
module crcbs_geom (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [crcbs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [crcbs_pkg::CSR_DATA_W-1:0]    csr_data,
   output crcbs_pkg::geom_type                 geom,
   output logic                                geom_ready
);
   import crcbs_pkg::*;

   typedef enum logic [2:0] {G_START, G_REGION, G_DIV1, G_DIV2, G_NEXT, G_IDLE} gstate_type;

   gstate_type               state_ff;
   logic [BLK_W-1:0]         block_size_ff;
   logic [2:0]               device_count_ff;
   logic [DEVBYTES_W-1:0]    dev_bytes_ff [NUM_DEV_REGS];
   geom_type                 geom_ff;
   logic [DEV_W-1:0]         d_ff;
   logic [MEM_AW-1:0]        acc_start_ff;
   logic [BASE_W-1:0]        acc_base_ff;
   logic [17:0]              dvd_ff;
   logic [BLK_W-1:0]         rem_ff;
   logic [17:0]              quo_ff;
   logic [4:0]               step_ff;
   logic [PAGE_W-1:0]        pages_ff;

   logic [BLK_W-1:0]         b_eff;
   logic [3:0]               n_eff;
   logic [DEVBYTES_W-1:0]    bytes_sel;
   logic [BLK_W:0]           rem_sh;
   logic                     ge;
   logic [BLK_W-1:0]         rem_nx;
   logic [17:0]              quo_nx;
   logic [PAGE_W-1:0]        pd_nx;

   assign b_eff = (block_size_ff > BLK_W'(MAX_BLOCK_BYTES)) ? BLK_W'(MAX_BLOCK_BYTES)
                                                           : block_size_ff;
   assign n_eff = ({1'b0, device_count_ff} > 4'(MAX_DEVICES)) ? 4'(MAX_DEVICES)
                                                             : {1'b0, device_count_ff};

   always_comb begin
      bytes_sel = '0;
      for (int i = 0; i < NUM_DEV_REGS; i++) begin
         if (32'(d_ff) == i) bytes_sel = dev_bytes_ff[i];
      end
   end

   // one restoring step per cycle
   assign rem_sh = {rem_ff, dvd_ff[17]};
   assign ge     = rem_sh >= {1'b0, b_eff};
   assign rem_nx = ge ? BLK_W'(rem_sh - {1'b0, b_eff}) : BLK_W'(rem_sh);
   assign quo_nx = {quo_ff[16:0], ge};
   assign pd_nx  = quo_nx[PAGE_W-1:0];

   assign csr_ready  = 1'b1;
   assign geom       = geom_ff;
   assign geom_ready = (state_ff == G_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= G_START;
         block_size_ff   <= BLK_W'(512);
         device_count_ff <= 3'd1;
         dev_bytes_ff[0] <= DEVBYTES_W'(65536);
         for (int i = 1; i < NUM_DEV_REGS; i++) dev_bytes_ff[i] <= '0;
      end else if (csr_valid) begin
         state_ff <= G_START;
         case (csr_index)
            CSR_BLOCK_SIZE:   block_size_ff   <= csr_data[BLK_W-1:0];
            CSR_DEVICE_COUNT: device_count_ff <= csr_data[2:0];
            CSR_DEV0_BYTES:   dev_bytes_ff[0] <= csr_data;
            CSR_DEV1_BYTES:   dev_bytes_ff[1] <= csr_data;
            CSR_DEV2_BYTES:   dev_bytes_ff[2] <= csr_data;
            CSR_DEV3_BYTES:   dev_bytes_ff[3] <= csr_data;
            default: ;
         endcase
      end else begin
         case (state_ff)
            G_START: begin
               geom_ff.blk_bytes <= b_eff;
               geom_ff.blk_small <= (b_eff < BLK_W'(2));
               d_ff              <= '0;
               acc_start_ff      <= '0;
               acc_base_ff       <= '0;
               state_ff          <= G_REGION;
            end
            G_REGION: begin
               geom_ff.start[d_ff] <= acc_start_ff;
               geom_ff.base[d_ff]  <= acc_base_ff;
               if ((4'(d_ff) < n_eff) && !(b_eff < BLK_W'(2))) begin
                  dvd_ff   <= 18'(bytes_sel);
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  step_ff  <= 5'd17;
                  state_ff <= G_DIV1;
               end else begin
                  geom_ff.used[d_ff] <= '0;
                  geom_ff.pd[d_ff]   <= '0;
                  state_ff           <= G_NEXT;
               end
            end
            G_DIV1: begin
               dvd_ff  <= {dvd_ff[16:0], 1'b0};
               rem_ff  <= rem_nx;
               quo_ff  <= quo_nx;
               step_ff <= step_ff - 5'd1;
               if (step_ff == '0) begin
                  // pages known; next divide gives the checksum page count
                  pages_ff <= quo_nx[PAGE_W-1:0];
                  dvd_ff   <= {1'b0, quo_nx[PAGE_W-1:0], 1'b0} + 18'(b_eff) - 18'd1;
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  step_ff  <= 5'd17;
                  state_ff <= G_DIV2;
               end
            end
            G_DIV2: begin
               dvd_ff  <= {dvd_ff[16:0], 1'b0};
               rem_ff  <= rem_nx;
               quo_ff  <= quo_nx;
               step_ff <= step_ff - 5'd1;
               if (step_ff == '0) begin
                  geom_ff.pd[d_ff]   <= pd_nx;
                  geom_ff.used[d_ff] <= (pages_ff > pd_nx) ? pages_ff - pd_nx : '0;
                  state_ff           <= G_NEXT;
               end
            end
            G_NEXT: begin
               acc_start_ff <= acc_start_ff + MEM_AW'(bytes_sel);
               acc_base_ff  <= acc_base_ff + BASE_W'(geom_ff.used[d_ff]);
               if (32'(d_ff) == MAX_DEVICES - 1) begin
                  state_ff <= G_IDLE;
               end else begin
                  d_ff     <= d_ff + DEV_W'(1);
                  state_ff <= G_REGION;
               end
            end
            default: ;
         endcase
      end
   end
endmodule

// ===== rtl/crcbs_front.sv =====
// Front end: takes request beats, maps the block number, queues them for the back end.
module crcbs_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [1:0]                        req_opcode,
   input  logic [crcbs_pkg::BLKNUM_W-1:0]    req_block_number,
   input  logic [7:0]                        req_data_in,
   input  crcbs_pkg::geom_type               geom,
   input  logic                              geom_ready,
   input  logic                              q_pop,
   output logic                              q_valid,
   output crcbs_pkg::entry_type              q_entry
);
   import crcbs_pkg::*;

   localparam int QDEPTH = 2;

   logic                  s1_valid_ff;
   op_type                s1_op_ff;
   logic [BLKNUM_W-1:0]   s1_blk_ff;
   logic [7:0]            s1_din_ff;
   logic                  s1_hit_ff;
   logic [PAGE_W-1:0]     s1_page_ff;
   logic [PAGE_W-1:0]     s1_pd_ff;
   logic [MEM_AW-1:0]     s1_start_ff;

   entry_type             fifo_ff [QDEPTH];
   logic                  wr_ptr_ff;
   logic                  rd_ptr_ff;
   logic [1:0]            count_ff;

   logic                  hit;
   logic [PAGE_W-1:0]     page;
   logic [PAGE_W-1:0]     pd_sel;
   logic [MEM_AW-1:0]     start_sel;
   logic [BASE_W-1:0]     blk_w;
   logic [PAGE_W-1:0]     span;
   logic [PAGE_W+BLK_W-1:0] prod;
   entry_type             s2_entry;
   logic                  q_full;
   logic                  push;
   logic                  accept;

   assign q_full   = (count_ff == 2'(QDEPTH));
   assign push     = s1_valid_ff && !q_full;
   assign req_full = !geom_ready || (s1_valid_ff && !push);
   assign accept   = req_push && !req_full;
   assign q_valid  = (count_ff != '0);
   assign q_entry  = fifo_ff[rd_ptr_ff];

   // regions are disjoint in block number, so at most one matches
   always_comb begin
      hit       = 1'b0;
      page      = '0;
      pd_sel    = '0;
      start_sel = '0;
      blk_w     = BASE_W'(req_block_number);
      for (int d = 0; d < MAX_DEVICES; d++) begin
         if ((blk_w >= geom.base[d]) && (blk_w < geom.base[d] + BASE_W'(geom.used[d]))) begin
            hit       = 1'b1;
            page      = PAGE_W'(blk_w - geom.base[d]);
            pd_sel    = geom.pd[d];
            start_sel = geom.start[d];
         end
      end
      if (geom.blk_small) hit = 1'b0;
   end

   always_comb begin
      span           = s1_page_ff + s1_pd_ff;
      prod           = span * geom.blk_bytes;
      s2_entry.op    = s1_op_ff;
      s2_entry.blk   = s1_blk_ff;
      s2_entry.din   = s1_din_ff;
      s2_entry.hit   = s1_hit_ff;
      s2_entry.dbase = s1_start_ff + prod[MEM_AW-1:0];
      s2_entry.cs    = s1_start_ff + MEM_AW'({s1_page_ff, 1'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wr_ptr_ff   <= 1'b0;
         rd_ptr_ff   <= 1'b0;
         count_ff    <= '0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
            s1_op_ff    <= op_type'(req_opcode);
            s1_blk_ff   <= req_block_number;
            s1_din_ff   <= req_data_in;
            s1_hit_ff   <= hit;
            s1_page_ff  <= page;
            s1_pd_ff    <= pd_sel;
            s1_start_ff <= start_sel;
         end else if (push) begin
            s1_valid_ff <= 1'b0;
         end
         if (push) begin
            fifo_ff[wr_ptr_ff] <= s2_entry;
            wr_ptr_ff          <= !wr_ptr_ff;
         end
         if (q_pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(q_pop);
      end
   end
endmodule

// ===== rtl/crcbs_back.sv =====
// Back end: byte memory, CRC accumulation, checksum store/check, erase walk, result register.
module crcbs_back (
   input  logic                  clock,
   input  logic                  reset,
   input  crcbs_pkg::geom_type   geom,
   input  logic                  q_valid,
   input  crcbs_pkg::entry_type  q_entry,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [7:0]            rsp_data_out,
   output logic [1:0]            rsp_status,
   output logic                  rsp_block_done,
   output logic                  rsp_crc_unset,
   output logic [15:0]           rsp_crc_value
);
   import crcbs_pkg::*;

   typedef enum logic [3:0] {
      B_CLEAR, B_IDLE, B_EXEC, B_RCS_HI, B_RCS_END, B_RCHK, B_RDATA,
      B_WCS_LO, B_WCS_HI, B_ERASE
   } bstate_type;

   bstate_type            state_ff;
   logic [MEM_AW-1:0]     clr_ff;
   logic [BLK_W-1:0]      cnt_ff;
   logic [15:0]           crc_ff;
   op_type                cur_op_ff;
   logic [BLKNUM_W-1:0]   cur_blk_ff;
   logic                  berr_ff;
   logic [15:0]           stored_ff;

   op_type                it_op_ff;
   logic [7:0]            it_din_ff;
   logic [MEM_AW-1:0]     it_dbase_ff;
   logic [MEM_AW-1:0]     it_cs_ff;
   logic [BLK_W-1:0]      it_cnt_ff;
   logic                  it_first_ff;
   logic                  it_last_ff;

   logic [DEV_W-1:0]      ed_ff;
   logic [PAGE_W-1:0]     ep_ff;
   logic                  eh_ff;

   logic                  out_valid_ff;
   logic [7:0]            out_data_ff;
   logic [1:0]            out_status_ff;
   logic                  out_done_ff;
   logic                  out_unset_ff;
   logic [15:0]           out_crc_ff;

   logic                  mem_we;
   logic [MEM_AW-1:0]     mem_addr;
   logic [7:0]            mem_wdata;
   logic [7:0]            mem_rdata;

   logic [BLK_W-1:0]      cnt_eff;
   logic                  last_eff;
   logic [15:0]           crc_w;
   logic [15:0]           crc_r;
   logic [MEM_AW-1:0]     data_addr;
   logic                  erase_active;

   crcbs_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_store (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // a beat for another block or opcode drops the block in progress
   assign cnt_eff  = ((cnt_ff != '0) && ((q_entry.op != cur_op_ff) || (q_entry.blk != cur_blk_ff)))
                     ? '0 : cnt_ff;
   assign last_eff = geom.blk_small || (({1'b0, cnt_eff} + (BLK_W+1)'(1)) >= {1'b0, geom.blk_bytes});
   assign crc_w    = crc_byte(crc_ff, it_din_ff);
   assign crc_r    = crc_byte(crc_ff, mem_rdata);
   assign data_addr    = it_dbase_ff + MEM_AW'(it_cnt_ff);
   assign erase_active = ep_ff < geom.used[ed_ff];

   assign q_pop = (state_ff == B_IDLE) && q_valid && (!out_valid_ff || rsp_pop);

   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = data_addr;
      mem_wdata = ERASED_BYTE;
      case (state_ff)
         B_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
         end
         B_EXEC: begin
            if (it_op_ff == OP_WRITE && !berr_ff) begin
               mem_we    = 1'b1;
               mem_wdata = it_din_ff;
            end else if (it_first_ff) begin
               mem_addr = it_cs_ff;
            end
         end
         B_RCS_HI: mem_addr = it_cs_ff + MEM_AW'(1);
         B_WCS_LO: begin
            mem_we    = 1'b1;
            mem_addr  = it_cs_ff;
            mem_wdata = crc_ff[7:0];
         end
         B_WCS_HI: begin
            mem_we    = 1'b1;
            mem_addr  = it_cs_ff + MEM_AW'(1);
            mem_wdata = crc_ff[15:8];
         end
         B_ERASE: begin
            mem_we   = erase_active;
            mem_addr = geom.start[ed_ff] + MEM_AW'({ep_ff, 1'b0}) + MEM_AW'(eh_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         crc_ff       <= CRC_INIT;
         cur_op_ff    <= OP_WRITE;
         cur_blk_ff   <= '0;
         berr_ff      <= 1'b0;
         stored_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rsp_pop && out_valid_ff) out_valid_ff <= 1'b0;
         case (state_ff)
            B_CLEAR: begin
               clr_ff <= clr_ff + MEM_AW'(1);
               if (clr_ff == '1) state_ff <= B_IDLE;
            end
            B_IDLE: begin
               if (q_pop) begin
                  it_op_ff    <= q_entry.op;
                  it_din_ff   <= q_entry.din;
                  it_dbase_ff <= q_entry.dbase;
                  it_cs_ff    <= q_entry.cs;
                  it_cnt_ff   <= cnt_eff;
                  it_first_ff <= (cnt_eff == '0);
                  it_last_ff  <= last_eff;
                  if ((q_entry.op == OP_WRITE || q_entry.op == OP_READ) && cnt_eff == '0) begin
                     cur_op_ff  <= q_entry.op;
                     cur_blk_ff <= q_entry.blk;
                     crc_ff     <= CRC_INIT;
                     berr_ff    <= !q_entry.hit;
                  end
                  state_ff <= B_EXEC;
               end
            end
            B_EXEC: begin
               case (it_op_ff)
                  OP_IGNORE: begin
                     out_valid_ff  <= 1'b1;
                     out_data_ff   <= '0;
                     out_status_ff <= STATUS_OK;
                     out_done_ff   <= 1'b0;
                     out_unset_ff  <= 1'b0;
                     out_crc_ff    <= '0;
                     state_ff      <= B_IDLE;
                  end
                  OP_ERASE: begin
                     cnt_ff   <= '0;
                     crc_ff   <= CRC_INIT;
                     ed_ff    <= '0;
                     ep_ff    <= '0;
                     eh_ff    <= 1'b0;
                     state_ff <= B_ERASE;
                  end
                  default: begin
                     cnt_ff <= it_last_ff ? '0 : it_cnt_ff + BLK_W'(1);
                     if (berr_ff) begin
                        out_valid_ff  <= 1'b1;
                        out_data_ff   <= '0;
                        out_status_ff <= STATUS_BAD;
                        out_done_ff   <= it_last_ff;
                        out_unset_ff  <= 1'b0;
                        out_crc_ff    <= CRC_INIT;
                        state_ff      <= B_IDLE;
                     end else if (it_op_ff == OP_WRITE) begin
                        crc_ff <= crc_w;
                        if (it_last_ff) begin
                           state_ff <= B_WCS_LO;
                        end else begin
                           out_valid_ff  <= 1'b1;
                           out_data_ff   <= '0;
                           out_status_ff <= STATUS_OK;
                           out_done_ff   <= 1'b0;
                           out_unset_ff  <= 1'b0;
                           out_crc_ff    <= crc_w;
                           state_ff      <= B_IDLE;
                        end
                     end else begin
                        state_ff <= it_first_ff ? B_RCS_HI : B_RCHK;
                     end
                  end
               endcase
            end
            B_RCS_HI: begin
               stored_ff[7:0] <= mem_rdata;
               state_ff       <= B_RCS_END;
            end
            B_RCS_END: begin
               stored_ff[15:8] <= mem_rdata;
               state_ff        <= B_RCHK;
            end
            B_RCHK: begin
               if (stored_ff == CRC_INIT) begin
                  // unset checksum: block reads back as zeros
                  out_valid_ff  <= 1'b1;
                  out_data_ff   <= '0;
                  out_status_ff <= STATUS_OK;
                  out_done_ff   <= it_last_ff;
                  out_unset_ff  <= 1'b1;
                  out_crc_ff    <= CRC_INIT;
                  state_ff      <= B_IDLE;
               end else begin
                  state_ff <= B_RDATA;
               end
            end
            B_RDATA: begin
               crc_ff        <= crc_r;
               out_valid_ff  <= 1'b1;
               out_data_ff   <= mem_rdata;
               out_status_ff <= (it_last_ff && crc_r != stored_ff) ? STATUS_MISMATCH : STATUS_OK;
               out_done_ff   <= it_last_ff;
               out_unset_ff  <= 1'b0;
               out_crc_ff    <= crc_r;
               state_ff      <= B_IDLE;
            end
            B_WCS_LO: state_ff <= B_WCS_HI;
            B_WCS_HI: begin
               out_valid_ff  <= 1'b1;
               out_data_ff   <= '0;
               out_status_ff <= STATUS_OK;
               out_done_ff   <= 1'b1;
               out_unset_ff  <= 1'b0;
               out_crc_ff    <= crc_ff;
               state_ff      <= B_IDLE;
            end
            B_ERASE: begin
               if (erase_active) begin
                  eh_ff <= !eh_ff;
                  if (eh_ff) ep_ff <= ep_ff + PAGE_W'(1);
               end else begin
                  ep_ff <= '0;
                  eh_ff <= 1'b0;
                  if (32'(ed_ff) == MAX_DEVICES - 1) begin
                     out_valid_ff  <= 1'b1;
                     out_data_ff   <= '0;
                     out_status_ff <= STATUS_OK;
                     out_done_ff   <= 1'b1;
                     out_unset_ff  <= 1'b0;
                     out_crc_ff    <= CRC_INIT;
                     state_ff      <= B_IDLE;
                  end else begin
                     ed_ff <= ed_ff + DEV_W'(1);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_data_out   = out_data_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_block_done = out_done_ff;
   assign rsp_crc_unset  = out_unset_ff;
   assign rsp_crc_value  = out_crc_ff;
endmodule

// ===== rtl/crc_checked_block_store_top.sv =====
// Top level of the CRC-16 checked block store.
//
// Byte-wide block store over a 64 KiB single-port RAM split into up to four device regions,
// each region keeping CRC-16 (poly 0x8408, init 0xFFFF) page checksums in its leading pages.
// Request beats enter a two-stage front end (block mapping, one 16x13 multiply) and a two-entry
// queue; the back end runs one beat at a time against the RAM port, which sets the rate. A write
// byte is stored from the execute state; a read byte adds a check state and, when it returns
// data, a data state. The last write byte adds the states that store the low and high checksum
// bytes, and the first read byte the states that fetch the stored checksum. Erase walks both
// checksum bytes of every usable page, region by region. After reset a clearing pass fills the
// RAM with 0xFF before the first beat is served (beats still queue meanwhile). After reset and
// after every register write the region geometry is recomputed by a bit-serial divider, while
// req_full stays high.
module crc_checked_block_store_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [1:0]                        req_opcode,
   input  logic [crcbs_pkg::BLKNUM_W-1:0]    req_block_number,
   input  logic [7:0]                        req_data_in,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [7:0]                        rsp_data_out,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_block_done,
   output logic                              rsp_crc_unset,
   output logic [15:0]                       rsp_crc_value,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [crcbs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [crcbs_pkg::CSR_DATA_W-1:0]  csr_data
);
   import crcbs_pkg::*;

   geom_type   geom;
   logic       geom_ready;
   logic       q_valid;
   logic       q_pop;
   entry_type  q_entry;

   crcbs_geom u_geom (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .geom       (geom),
      .geom_ready (geom_ready)
   );

   crcbs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_opcode       (req_opcode),
      .req_block_number (req_block_number),
      .req_data_in      (req_data_in),
      .geom             (geom),
      .geom_ready       (geom_ready),
      .q_pop            (q_pop),
      .q_valid          (q_valid),
      .q_entry          (q_entry)
   );

   crcbs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .geom           (geom),
      .q_valid        (q_valid),
      .q_entry        (q_entry),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_data_out   (rsp_data_out),
      .rsp_status     (rsp_status),
      .rsp_block_done (rsp_block_done),
      .rsp_crc_unset  (rsp_crc_unset),
      .rsp_crc_value  (rsp_crc_value)
   );

`ifndef SYNTH
   a_geom_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      !geom_ready |-> req_full)
      else $error("request taken while geometry is recomputed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_status == STATUS_OK || rsp_status == STATUS_BAD ||
                      rsp_status == STATUS_MISMATCH))
      else $error("undefined status code on result");

   a_unset_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_crc_unset) |-> (rsp_data_out == 8'h00 && rsp_crc_value == CRC_INIT))
      else $error("unset checksum result carries data");
`endif
endmodule

// ===== tb/tb_crc_checked_block_store_top.sv =====
// Self-checking testbench for the CRC-16 checked block store top level.
module tb_crc_checked_block_store_top;
   timeunit 1ns;
   timeprecision 1ps;

   import crcbs_pkg::*;

   typedef struct packed {
      logic [7:0]  dout;
      logic [1:0]  st;
      logic        done;
      logic        unset;
      logic [15:0] crc;
   } rsp_beat_type;

   typedef struct packed {
      op_type        op;
      logic [14:0]   blk;
      logic [7:0]    din;
      logic          typed;
      rsp_beat_type  res;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_push;
   logic                  req_full;
   logic [1:0]            req_opcode;
   logic [BLKNUM_W-1:0]   req_block_number;
   logic [7:0]            req_data_in;
   logic                  rsp_empty;
   logic                  rsp_pop;
   logic [7:0]            rsp_data_out;
   logic [1:0]            rsp_status;
   logic                  rsp_block_done;
   logic                  rsp_crc_unset;
   logic [15:0]           rsp_crc_value;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   crc_checked_block_store_top DUT (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // shadow of the block's registers and storage
   int unsigned   sh_block_size, sh_dev_count;
   int unsigned   sh_dev_bytes [4];
   logic [7:0]    sh_mem [MEM_BYTES];
   logic [15:0]   sh_crc, sh_stored_cs;
   int unsigned   sh_count;
   logic          sh_err;
   op_type        sh_op;
   logic [14:0]   sh_blk;
   longint        sh_dbase, sh_cs;

   rsp_beat_type  expected_rsp_q [$];
   int            errors = 0;
   int            beats_sent = 0;
   int            erases_sent = 0;
   int            settings_run = 0;
   int            rsp_hold = 0;
   bit            no_idle = 0;

   function automatic int unsigned eff_block();
      return (sh_block_size > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : sh_block_size;
   endfunction

   function automatic int unsigned eff_devs();
      return (sh_dev_count > MAX_DEVICES) ? MAX_DEVICES : sh_dev_count;
   endfunction

   function automatic longint usable(longint bytes, longint b, output longint pd);
      longint pages;
      pages = bytes / b;
      pd = (pages * 2 + b - 1) / b;
      return (pages > pd) ? pages - pd : 0;
   endfunction

   function automatic longint total_blocks();
      longint b, pd, sum;
      b = eff_block();
      sum = 0;
      if (b >= 2)
         for (int d = 0; d < eff_devs(); d++) sum += usable(sh_dev_bytes[d], b, pd);
      return sum;
   endfunction

   function automatic bit map_block(logic [14:0] blk, longint b);
      longint base, start, pd, nuse, page;
      base = 0;
      start = 0;
      if (b < 2) return 0;
      for (int d = 0; d < eff_devs(); d++) begin
         nuse = usable(sh_dev_bytes[d], b, pd);
         if (blk >= base && blk < base + nuse) begin
            page = blk - base;
            sh_dbase = start + (page + pd) * b;
            sh_cs = start + page * 2;
            return 1;
         end
         base += nuse;
         start += sh_dev_bytes[d];
      end
      return 0;
   endfunction

   function automatic logic [15:0] crc_update(logic [15:0] c, logic [7:0] v);
      logic [15:0] x;
      x = c ^ {8'h00, v};
      for (int i = 0; i < 8; i++) x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
      return x;
   endfunction

   function automatic void erase_checksums();
      longint b, start, pd, nuse;
      b = eff_block();
      start = 0;
      if (b < 2) return;
      for (int d = 0; d < eff_devs(); d++) begin
         nuse = usable(sh_dev_bytes[d], b, pd);
         for (longint p = 0; p < nuse; p++) begin
            sh_mem[16'(start + p * 2)] = ERASED_BYTE;
            sh_mem[16'(start + p * 2 + 1)] = ERASED_BYTE;
         end
         start += sh_dev_bytes[d];
      end
   endfunction

   function automatic rsp_beat_type predict_rsp(op_type op, logic [14:0] blk, logic [7:0] din);
      rsp_beat_type r;
      longint b;
      bit last;
      r = '0;
      if (op == OP_ERASE) begin
         erase_checksums();
         sh_count = 0;
         sh_crc = CRC_INIT;
         r.done = 1'b1;
         r.crc = CRC_INIT;
      end else if (op != OP_IGNORE) begin
         b = eff_block();
         if (sh_count != 0 && (op != sh_op || blk != sh_blk)) sh_count = 0;
         if (sh_count == 0) begin
            sh_op = op;
            sh_blk = blk;
            sh_crc = CRC_INIT;
            sh_err = !map_block(blk, b);
            if (!sh_err && op == OP_READ)
               sh_stored_cs = {sh_mem[16'(sh_cs + 1)], sh_mem[16'(sh_cs)]};
         end
         last = (b < 2) || (sh_count + 1 >= b);
         if (sh_err) begin
            r.st = STATUS_BAD;
            r.crc = CRC_INIT;
         end else if (op == OP_WRITE) begin
            sh_mem[16'(sh_dbase + sh_count)] = din;
            sh_crc = crc_update(sh_crc, din);
            if (last) begin
               sh_mem[16'(sh_cs)] = sh_crc[7:0];
               sh_mem[16'(sh_cs + 1)] = sh_crc[15:8];
            end
            r.crc = sh_crc;
         end else if (sh_stored_cs == 16'hFFFF) begin
            r.unset = 1'b1;
            r.crc = CRC_INIT;
         end else begin
            r.dout = sh_mem[16'(sh_dbase + sh_count)];
            sh_crc = crc_update(sh_crc, r.dout);
            if (last && sh_crc != sh_stored_cs) r.st = STATUS_MISMATCH;
            r.crc = sh_crc;
         end
         sh_count = last ? 0 : sh_count + 1;
         r.done = last;
      end
      return r;
   endfunction

   task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
      errors++;
      $display("mismatch %s: expected %0h got %0h at %0t", what, exp_v, got_v, $realtime);
   endtask

   // one beat into the request queue
   task automatic send_beat(op_type op, logic [14:0] blk, logic [7:0] din,
                            bit typed = 0, rsp_beat_type res = '0);
      int gap;
      rsp_beat_type pred;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_opcode <= op;
      req_block_number <= blk;
      req_data_in <= din;
      @(posedge clock);
      while (req_full) @(posedge clock);
      pred = predict_rsp(op, blk, din);
      expected_rsp_q.push_back(typed ? res : pred);
      beats_sent++;
      if (op == OP_ERASE) erases_sent++;
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_BLOCK_SIZE:   sh_block_size = value & 32'h1FFF;
         CSR_DEVICE_COUNT: sh_dev_count = value & 32'h7;
         CSR_DEV0_BYTES:   sh_dev_bytes[0] = value & 32'h1FFFF;
         CSR_DEV1_BYTES:   sh_dev_bytes[1] = value & 32'h1FFFF;
         CSR_DEV2_BYTES:   sh_dev_bytes[2] = value & 32'h1FFFF;
         CSR_DEV3_BYTES:   sh_dev_bytes[3] = value & 32'h1FFFF;
         default: ;
      endcase
   endtask

   task automatic apply_setting(int unsigned bs, int unsigned dc, int unsigned d0,
                                int unsigned d1, int unsigned d2, int unsigned d3);
      drain();
      csr_write(CSR_BLOCK_SIZE, bs);
      csr_write(CSR_DEVICE_COUNT, dc);
      csr_write(CSR_DEV0_BYTES, d0);
      csr_write(CSR_DEV1_BYTES, d1);
      csr_write(CSR_DEV2_BYTES, d2);
      csr_write(CSR_DEV3_BYTES, d3);
      settings_run++;
   endtask

   // mostly whole blocks on a small pool of block numbers, some noise
   task automatic random_traffic(int n_beats);
      int sent, r, len, k;
      longint nblk, pool;
      op_type op;
      logic [14:0] blk;
      sent = 0;
      while (sent < n_beats) begin
         nblk = total_blocks();
         r = $urandom_range(0, 99);
         if (r < 1) begin
            send_beat(OP_ERASE, 15'($urandom), 8'($urandom));
            sent++;
         end else if (r < 3) begin
            send_beat(OP_IGNORE, 15'($urandom), 8'($urandom));
         end else if (r < 10) begin
            send_beat(op_type'($urandom_range(0, 1)), 15'($urandom), 8'($urandom));
            sent++;
         end else begin
            op = op_type'($urandom_range(0, 1));
            k = $urandom_range(0, 9);
            pool = (nblk < 6) ? nblk : 6;
            if (nblk == 0 || k == 9) blk = 15'($urandom);
            else if (k < 7) blk = 15'($urandom_range(0, int'(pool) - 1));
            else blk = 15'(nblk - 1);
            len = (eff_block() < 2) ? 1 : eff_block();
            if (len > 64) len = $urandom_range(1, 64);
            if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len);
            for (int i = 0; i < len; i++) send_beat(op, blk, 8'($urandom));
            sent += len;
         end
      end
   endtask

   function automatic stim_row_type row(op_type op, logic [14:0] blk, logic [7:0] din,
                                        logic typed = 0, rsp_beat_type res = '0);
      return '{op, blk, din, typed, res};
   endfunction

   // result side: random pop gaps, long hold-off on request
   initial begin
      int gap;
      rsp_beat_type want, got;
      rsp_pop = 1'b0;
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 3);
         if (rsp_hold > 0) begin
            gap = rsp_hold;
            rsp_hold = 0;
         end
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty || reset) @(posedge clock);
         got = '{rsp_data_out, rsp_status, rsp_block_done, rsp_crc_unset, rsp_crc_value};
         if (expected_rsp_q.size() == 0) begin
            report("unexpected beat", 32'd0, 32'(got));
         end else begin
            want = expected_rsp_q.pop_front();
            if (got.dout !== want.dout) report("data_out", 32'(want.dout), 32'(got.dout));
            if (got.st !== want.st) report("status", 32'(want.st), 32'(got.st));
            if (got.done !== want.done) report("block_done", 32'(want.done), 32'(got.done));
            if (got.unset !== want.unset)
               report("crc_unset", 32'(want.unset), 32'(got.unset));
            if (got.crc !== want.crc) report("crc_value", 32'(want.crc), 32'(got.crc));
         end
      end
   end

   initial begin
      #60_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      stim_row_type dir_q [$];
      rsp_beat_type unset_rd, bad_wr;
      reset = 1'b1;
      req_push = 1'b0;
      req_opcode = OP_WRITE;
      req_block_number = '0;
      req_data_in = '0;
      csr_valid = 1'b0;
      csr_index = CSR_BLOCK_SIZE;
      csr_data = '0;
      sh_block_size = 512;
      sh_dev_count = 1;
      sh_dev_bytes = '{65536, 0, 0, 0};
      foreach (sh_mem[i]) sh_mem[i] = ERASED_BYTE;
      sh_crc = CRC_INIT;
      sh_stored_cs = '0;
      sh_count = 0;
      sh_err = 0;
      sh_op = OP_WRITE;
      sh_blk = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      csr_write(CSR_BLOCK_SIZE, 4);
      unset_rd = '{8'h00, STATUS_OK, 1'b0, 1'b1, 16'hFFFF};
      bad_wr = '{8'h00, STATUS_BAD, 1'b0, 1'b0, 16'hFFFF};
      // fresh storage reads as unset
      for (int i = 0; i < 3; i++) dir_q.push_back(row(OP_READ, 15'd0, 8'h00, 1, unset_rd));
      dir_q.push_back(row(OP_READ, 15'd0, 8'h00, 1, '{8'h00, STATUS_OK, 1'b1, 1'b1, 16'hFFFF}));
      dir_q.push_back(row(OP_WRITE, 15'd1, 8'h00));
      dir_q.push_back(row(OP_WRITE, 15'd1, 8'hFF));
      dir_q.push_back(row(OP_WRITE, 15'd1, 8'hA5));
      dir_q.push_back(row(OP_WRITE, 15'd1, 8'h5A));
      for (int i = 0; i < 4; i++) dir_q.push_back(row(OP_READ, 15'd1, 8'h00));
      // out of range block, then opcode change drops it
      dir_q.push_back(row(OP_WRITE, 15'h7FFF, 8'hFF, 1, bad_wr));
      dir_q.push_back(row(OP_READ, 15'd8191, 8'h00));
      dir_q.push_back(row(OP_IGNORE, 15'h7FFF, 8'hFF, 1, '0));
      // corrupt a data byte behind the checksum to get a mismatch
      for (int i = 0; i < 4; i++) dir_q.push_back(row(OP_WRITE, 15'd2, 8'(8'h31 + i)));
      dir_q.push_back(row(OP_WRITE, 15'd2, 8'h77));
      for (int i = 0; i < 4; i++) dir_q.push_back(row(OP_READ, 15'd2, 8'h00));
      dir_q.push_back(row(OP_ERASE, 15'd0, 8'h00, 1, '{8'h00, STATUS_OK, 1'b1, 1'b0, 16'hFFFF}));
      dir_q.push_back(row(OP_READ, 15'd1, 8'h00, 1, unset_rd));
      foreach (dir_q[i]) send_beat(dir_q[i].op, dir_q[i].blk, dir_q[i].din,
                                   dir_q[i].typed, dir_q[i].res);

      apply_setting(4, 1, 65536, 0, 0, 0);
      rsp_hold = 300;
      random_traffic(160);
      apply_setting(8, 4, 1024, 2048, 0, 4096);
      random_traffic(160);
      no_idle = 1;
      apply_setting(2, 7, 256, 65536, 0, 512);
      random_traffic(120);
      no_idle = 0;
      apply_setting(16, 2, 131071, 131071, 0, 0);
      random_traffic(150);
      apply_setting(0, 3, 4096, 4096, 4096, 0);
      random_traffic(60);
      apply_setting(8191, 1, 65536, 0, 0, 0);
      random_traffic(80);
      apply_setting(1, 0, 0, 0, 0, 0);
      random_traffic(40);
      apply_setting(5, 4, 300, 0, 1000, 20000);
      random_traffic(160);
      apply_setting(512, 1, 65536, 0, 0, 0);
      random_traffic(100);
      drain();
      repeat (20) @(posedge clock);

      $display("Run covered %0d request beats (%0d erases) over %0d register settings,",
               beats_sent, erases_sent, settings_run);
      $display("including bad blocks, unset and mismatched checksums and a full queue stall.");
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
